/* hdl/dte_pkg.sv */
// package for the date/time to epoch microsecond converter
// shared types, status codes, calendar tables and small arithmetic helpers
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dte_pkg;

   localparam logic [15:0] EPOCH_YEAR       = 16'd1970;
   localparam logic [15:0] MAX_YEAR_RESET   = 16'd28808;
   localparam logic [63:0] MAX_USEC_RESET   = 64'hFFFF_FFFF_FFFF_FFFF;
   // leap years in 1..1969
   localparam logic [15:0] LEAPS_BEFORE_EPOCH = 16'd477;
   localparam logic [24:0] DAYS_PER_YEAR    = 25'd365;
   localparam logic [40:0] SEC_PER_DAY      = 41'd86400;
   localparam logic [16:0] SEC_PER_HOUR     = 17'd3600;
   localparam logic [16:0] SEC_PER_MIN      = 17'd60;
   localparam int unsigned SEC_TO_USEC      = 1000000;
   localparam int unsigned SEC_LO_W         = 21;
   localparam int unsigned SEC_W            = 41;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_YEAR  = 3'd1,
      ST_BAD_MONTH = 3'd2,
      ST_BAD_DAY   = 3'd3,
      ST_BAD_TIME  = 3'd4,
      ST_OVER      = 3'd5
   } dte_status_type;

   typedef enum logic [0:0] {
      CSR_MAX_YEAR = 1'b0,
      CSR_MAX_USEC = 1'b1
   } dte_csr_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DIV,
      S_CHECK,
      S_DAYS,
      S_SECS,
      S_MLO,
      S_MHI,
      S_SUM,
      S_DONE
   } dte_state_type;

   // one step enable per datapath phase
   typedef struct packed {
      logic load;
      logic div;
      logic check;
      logic days;
      logic secs;
      logic mlo;
      logic mhi;
      logic sum;
      logic done;
   } dte_cmd_type;

   // floor(x / 25) for x < 2^14, reciprocal multiply (5243 = ceil(2^17 / 25))
   function automatic logic [9:0] div25(input logic [13:0] x);
      logic [26:0] p;
      p = 27'(x) * 27'd5243;
      return p[26:17];
   endfunction

   function automatic logic [13:0] mul25(input logic [9:0] q);
      return 14'({q, 4'b0}) + 14'({q, 3'b0}) + 14'(q);
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] m);
      logic [4:0] len;
      unique case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

   // days in the months before m of a common year
   function automatic logic [8:0] cum_days(input logic [3:0] m);
      logic [8:0] d;
      unique case (m)
         4'd2:    d = 9'd31;
         4'd3:    d = 9'd59;
         4'd4:    d = 9'd90;
         4'd5:    d = 9'd120;
         4'd6:    d = 9'd151;
         4'd7:    d = 9'd181;
         4'd8:    d = 9'd212;
         4'd9:    d = 9'd243;
         4'd10:   d = 9'd273;
         4'd11:   d = 9'd304;
         4'd12:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

/* hdl/dte_ctrl.sv */
// sequencer for the date/time to epoch converter
// walks the datapath through its phases, drives busy and the result strobe
// depends on dte_pkg
`timescale 1ns / 1ps
`default_nettype none

module dte_ctrl
   import dte_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  start,
   output logic       busy,
   output logic       rsp_valid,
   output dte_cmd_type cmd
);

   dte_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div  = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = S_DAYS;
         end
         S_DAYS: begin
            cmd.days = 1'b1;
            state_in = S_SECS;
         end
         S_SECS: begin
            cmd.secs = 1'b1;
            state_in = S_MLO;
         end
         S_MLO: begin
            cmd.mlo  = 1'b1;
            state_in = S_MHI;
         end
         S_MHI: begin
            cmd.mhi  = 1'b1;
            state_in = S_SUM;
         end
         S_SUM: begin
            cmd.sum  = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            cmd.done     = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

/* hdl/dte_datapath.sv */
// datapath of the date/time to epoch converter: checks, day count, scaling
// holds the two configuration registers and the result registers
// depends on dte_pkg
`timescale 1ns / 1ps
`default_nettype none

module dte_datapath
   import dte_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire dte_cmd_type cmd,
   input  wire logic [15:0] req_year,
   input  wire logic [3:0]  req_month,
   input  wire logic [4:0]  req_day,
   input  wire logic [4:0]  req_hour,
   input  wire logic [5:0]  req_minute,
   input  wire logic [5:0]  req_sec,
   input  wire logic        csr_write_en,
   input  wire logic [0:0]  csr_index,
   input  wire logic [63:0] csr_wdata,
   output logic [63:0]      rsp_usec_total,
   output logic [2:0]       rsp_status
);

   logic [15:0] max_year_ff;
   logic [63:0] max_usec_ff;

   logic [15:0] year_ff;
   logic [3:0]  month_ff;
   logic [4:0]  day_ff;
   logic [4:0]  hour_ff;
   logic [5:0]  minute_ff;
   logic [5:0]  sec_ff;

   logic [9:0]  q100m1_ff, q400m1_ff, yq100_ff, yq400_ff;
   dte_status_type status_ff, status_in;
   logic [15:0] leaps_ff, leaps_in;
   logic [15:0] yoff_ff;
   logic [8:0]  mcum_ff, mcum_in;
   logic [16:0] tod_ff, tod_in;
   logic [24:0] days_ff, days_in;
   logic [SEC_W-1:0] secs_ff, secs_in;
   logic [40:0] plo_ff, plo_in;
   logic [39:0] phi_ff, phi_in;
   logic [63:0] usec_ff, usec_in;
   logic [63:0] out_usec_ff, out_usec_in;
   dte_status_type out_status_ff, out_status_in;

   logic [15:0] ym1;
   logic [13:0] yc;
   logic [13:0] yd;
   logic        div100, div400, leap;
   logic [4:0]  mdays;
   logic        over;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_year_ff <= MAX_YEAR_RESET;
         max_usec_ff <= MAX_USEC_RESET;
      end else if (csr_write_en) begin
         unique case (dte_csr_type'(csr_index))
            CSR_MAX_YEAR: max_year_ff <= csr_wdata[15:0];
            CSR_MAX_USEC: max_usec_ff <= csr_wdata;
            default:      ;
         endcase
      end
   end

   // divide phase helpers
   assign ym1 = year_ff - 16'd1;
   assign yc  = year_ff[15:2];
   assign yd  = {2'b0, year_ff[15:4]};

   // check phase: leap rule, month length, ordered checks
   always_comb begin
      div100   = (year_ff[1:0] == 2'b0) && (yc == mul25(yq100_ff));
      div400   = (year_ff[3:0] == 4'b0) && (yd == mul25(yq400_ff));
      leap     = ((year_ff[1:0] == 2'b0) && !div100) || div400;
      mdays    = (month_ff == 4'd2 && leap) ? 5'd29 : month_len(month_ff);
      priority if (year_ff < EPOCH_YEAR || year_ff > max_year_ff)
         status_in = ST_BAD_YEAR;
      else if (month_ff < 4'd1 || month_ff > 4'd12)
         status_in = ST_BAD_MONTH;
      else if (day_ff < 5'd1 || day_ff > mdays)
         status_in = ST_BAD_DAY;
      else if (hour_ff > 5'd23 || minute_ff > 6'd59 || sec_ff > 6'd59)
         status_in = ST_BAD_TIME;
      else
         status_in = ST_OK;
      leaps_in = {2'b0, ym1[15:2]} - 16'(q100m1_ff) + 16'(q400m1_ff) - LEAPS_BEFORE_EPOCH;
      mcum_in  = cum_days(month_ff) + 9'((leap && month_ff > 4'd2) ? 1'b1 : 1'b0);
      tod_in   = 17'(hour_ff) * SEC_PER_HOUR + 17'(minute_ff) * SEC_PER_MIN
               + 17'(sec_ff);
   end

   assign days_in = 25'(yoff_ff) * DAYS_PER_YEAR + 25'(leaps_ff) + 25'(mcum_ff)
                  + 25'(day_ff) - 25'd1;
   assign secs_in = SEC_W'(days_ff) * SEC_PER_DAY + SEC_W'(tod_ff);
   assign plo_in  = 41'(secs_ff[SEC_LO_W-1:0]) * 41'(SEC_TO_USEC);
   assign phi_in  = 40'(secs_ff[SEC_W-1:SEC_LO_W]) * 40'(SEC_TO_USEC);
   assign usec_in = {3'b0, phi_ff, 21'b0} + {23'b0, plo_ff};

   // final ceiling compare and zeroing of failed results
   always_comb begin
      over = (usec_ff > max_usec_ff);
      priority if (status_ff != ST_OK)
         out_status_in = status_ff;
      else if (over)
         out_status_in = ST_OVER;
      else
         out_status_in = ST_OK;
      out_usec_in = (out_status_in == ST_OK) ? usec_ff : 64'd0;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         year_ff   <= req_year;
         month_ff  <= req_month;
         day_ff    <= req_day;
         hour_ff   <= req_hour;
         minute_ff <= req_minute;
         sec_ff    <= req_sec;
      end
      if (cmd.div) begin
         q100m1_ff <= div25(ym1[15:2]);
         q400m1_ff <= div25({2'b0, ym1[15:4]});
         yq100_ff  <= div25(yc);
         yq400_ff  <= div25(yd);
      end
      if (cmd.check) begin
         status_ff <= status_in;
         leaps_ff  <= leaps_in;
         yoff_ff   <= year_ff - EPOCH_YEAR;
         mcum_ff   <= mcum_in;
         tod_ff    <= tod_in;
      end
      if (cmd.days) begin
         days_ff <= days_in;
      end
      if (cmd.secs) begin
         secs_ff <= secs_in;
      end
      if (cmd.mlo) begin
         plo_ff <= plo_in;
      end
      if (cmd.mhi) begin
         phi_ff <= phi_in;
      end
      if (cmd.sum) begin
         usec_ff <= usec_in;
      end
      if (cmd.done) begin
         out_usec_ff   <= out_usec_in;
         out_status_ff <= out_status_in;
      end
   end

   assign rsp_usec_total = out_usec_ff;
   assign rsp_status     = out_status_ff;

endmodule

`default_nettype wire

/* hdl/date_time_to_epoch_usec_core.sv */
// date/time to epoch microseconds: after the request transfer the sequencer runs
// eight phases (divide, check, day sum, seconds, two multiply halves, add,
// compare), one request at a time, then the result strobes on the return to idle
// rsp_valid strobes for one cycle; the receiver cannot stall
// synchronous active-high reset: sequencer idle, max_year 28808, max_usec all ones
// depends on dte_pkg, dte_ctrl, dte_datapath
`timescale 1ns / 1ps
`default_nettype none

module date_time_to_epoch_usec_core
   import dte_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // request transfer, taken when start is high and busy is low
   input  wire logic        start,
   output logic             busy,
   input  wire logic [15:0] req_year,
   input  wire logic [3:0]  req_month,
   input  wire logic [4:0]  req_day,
   input  wire logic [4:0]  req_hour,
   input  wire logic [5:0]  req_minute,
   input  wire logic [5:0]  req_sec,
   // result transfer, one cycle strobe
   output logic             rsp_valid,
   output logic [63:0]      rsp_usec_total,
   output logic [2:0]       rsp_status,
   // configuration writes, index 0 max_year, index 1 max_usec
   input  wire logic        csr_write_en,
   input  wire logic [0:0]  csr_index,
   input  wire logic [63:0] csr_wdata
);

   dte_cmd_type cmd;

   // sequencer: a new transfer is taken only in idle, the strobe leaves
   // together with the return to idle so the next request can start at once
   dte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   // datapath: year/100 and year/400 by reciprocal multiply, ordered checks,
   // closed-form day count, then seconds scaled to microseconds in two halves
   dte_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_year       (req_year),
      .req_month      (req_month),
      .req_day        (req_day),
      .req_hour       (req_hour),
      .req_minute     (req_minute),
      .req_sec        (req_sec),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_usec_total (rsp_usec_total),
      .rsp_status     (rsp_status)
   );

endmodule

`default_nettype wire
